// File: rtl/core/crs_pkg.sv
// Shared widths, codes and types of the ciphertext coefficient rescale core.
package crs_pkg;

    localparam int LANES    = 3;
    localparam int COEF_W   = 63;
    localparam int NUM_W    = COEF_W + 1;
    localparam int STEPS    = NUM_W;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(COEF_W);

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_T_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELTA_ZERO = 2'd2;

    localparam logic CFG_Q = 1'b0;
    localparam logic CFG_T = 1'b1;

    localparam logic [COEF_W-1:0] Q_RESET = 63'd65537;
    localparam logic [COEF_W-1:0] T_RESET = 63'd2;

    typedef logic [LANES-1:0][COEF_W-1:0] t_rem_vec;
    typedef logic [LANES-1:0][NUM_W-1:0]  t_num_vec;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [LANES-1:0] neg;
    } t_side;

    typedef struct packed {
        logic                busy;
        logic [COEF_W-1:0]   q;
        logic [COEF_W-2:0]   q_half;
        logic [COEF_W-1:0]   delta;
        logic [COEF_W-2:0]   d_half;
        logic [STATUS_W-1:0] status;
    } t_cfg;

endpackage

// File: rtl/core/crs_div_cell.sv
// One restoring division step over all lanes, registered.
module crs_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic [crs_pkg::COEF_W-1:0] i_den,
    input  crs_pkg::t_rem_vec          i_rem,
    input  crs_pkg::t_num_vec          i_num,
    input  crs_pkg::t_side             i_side,
    output crs_pkg::t_rem_vec          o_rem,
    output crs_pkg::t_num_vec          o_num,
    output crs_pkg::t_side             o_side
);

    crs_pkg::t_rem_vec r_rem, n_rem;
    crs_pkg::t_num_vec r_num, n_num;
    crs_pkg::t_side    r_side;

    always_comb begin
        logic [crs_pkg::NUM_W-1:0] trial;
        logic                      ge;
        for (int l = 0; l < crs_pkg::LANES; l++) begin
            trial = {i_rem[l], i_num[l][crs_pkg::NUM_W-1]};
            ge    = (trial >= {1'b0, i_den});
            n_rem[l] = ge ? crs_pkg::COEF_W'(trial - {1'b0, i_den})
                          : trial[crs_pkg::COEF_W-1:0];
            n_num[l] = {i_num[l][crs_pkg::NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_ce) begin
            r_side <= i_side;
        end
        if (i_ce) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_side = r_side;

endmodule

// File: rtl/core/crs_div_chain.sv
// Row of division cells: quotient and remainder of each lane after all steps.
module crs_div_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic [crs_pkg::COEF_W-1:0] i_den,
    input  crs_pkg::t_num_vec          i_num,
    input  crs_pkg::t_side             i_side,
    output crs_pkg::t_num_vec          o_quot,
    output crs_pkg::t_rem_vec          o_rem,
    output crs_pkg::t_side             o_side
);

    crs_pkg::t_rem_vec w_rem  [0:crs_pkg::STEPS];
    crs_pkg::t_num_vec w_num  [0:crs_pkg::STEPS];
    crs_pkg::t_side    w_side [0:crs_pkg::STEPS];

    assign w_rem[0]  = '0;
    assign w_num[0]  = i_num;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < crs_pkg::STEPS; s++) begin : g_cell
        crs_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (i_ce),
            .i_den  (i_den),
            .i_rem  (w_rem[s]),
            .i_num  (w_num[s]),
            .i_side (w_side[s]),
            .o_rem  (w_rem[s+1]),
            .o_num  (w_num[s+1]),
            .o_side (w_side[s+1])
        );
    end

    assign o_quot = w_num[crs_pkg::STEPS];
    assign o_rem  = w_rem[crs_pkg::STEPS];
    assign o_side = w_side[crs_pkg::STEPS];

endmodule

// File: rtl/core/crs_delta_unit.sv
// Configuration registers and the iterative divider that forms Delta = q / t.
module crs_delta_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [crs_pkg::COEF_W-1:0] i_cfg_data,
    output crs_pkg::t_cfg              o_cfg
);

    logic [crs_pkg::COEF_W-1:0] r_q, r_t, r_rem, r_quo;
    logic [crs_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_start, r_busy;
    logic [crs_pkg::NUM_W-1:0]  trial;
    logic                       ge;

    assign trial = {r_rem, r_quo[crs_pkg::COEF_W-1]};
    assign ge    = (trial >= {1'b0, r_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q     <= crs_pkg::Q_RESET;
            r_t     <= crs_pkg::T_RESET;
            r_start <= 1'b1;
            r_busy  <= 1'b1;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crs_pkg::CFG_Q: r_q <= i_cfg_data;
                crs_pkg::CFG_T: r_t <= i_cfg_data;
                default: ;
            endcase
            r_start <= 1'b1;
            r_busy  <= 1'b1;
        end else if (r_start) begin
            // Load the dividend; the quotient bits shift in behind it.
            r_start <= 1'b0;
            r_quo   <= r_q;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? crs_pkg::COEF_W'(trial - {1'b0, r_t})
                        : trial[crs_pkg::COEF_W-1:0];
            r_quo <= {r_quo[crs_pkg::COEF_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == crs_pkg::CNT_W'(crs_pkg::COEF_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cfg.busy   = r_start | r_busy;
        o_cfg.q      = r_q;
        o_cfg.q_half = r_q[crs_pkg::COEF_W-1:1];
        o_cfg.delta  = r_quo;
        o_cfg.d_half = r_quo[crs_pkg::COEF_W-1:1];
        if (r_t == '0) begin
            o_cfg.status = crs_pkg::ST_T_ZERO;
        end else if (r_quo == '0) begin
            o_cfg.status = crs_pkg::ST_DELTA_ZERO;
        end else begin
            o_cfg.status = crs_pkg::ST_OK;
        end
    end

endmodule

// File: rtl/core/ciphertext_coefficient_rescale_core.sv
// Top level of the ciphertext coefficient rescale core.
// Accepts one coefficient index (three residues) per cycle unless an output stall
// or the Delta divider holds it off, and returns the three residues rescaled by
// Delta = q / t, rounded to nearest with halves away from zero and reduced into
// [0, q): a register that centres the residues, one that adds Delta/2, 64 cells
// of a pipelined divider by Delta, 64 cells of a second one that reduces the
// quotient modulo q, and the output register. Stalls on the output side freeze
// the whole pipeline. After reset and after every configuration write, input is
// held off while a bit-serial divider forms Delta from the two registers.
module ciphertext_coefficient_rescale_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [crs_pkg::COEF_W-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // coef_zero [62:0], coef_one [125:63], coef_two [188:126], zero fill
    input  logic [191:0]               s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // res_zero [62:0], res_one [125:63], res_two [188:126], zero fill
    output logic [191:0]               m_axis_tdata,
    // status [1:0]
    output logic [crs_pkg::STATUS_W-1:0] m_axis_tuser,
    output logic                       m_axis_tlast
);

    crs_pkg::t_cfg     cfg;
    logic              ce;
    crs_pkg::t_side    r_a_side, r_b_side, w_q_side, w_r_side;
    crs_pkg::t_rem_vec r_a_mag, w_rem;
    crs_pkg::t_num_vec r_b_num, w_quot;
    crs_pkg::t_rem_vec r_out_res;
    logic              r_out_valid, r_out_last;
    logic [crs_pkg::STATUS_W-1:0] r_out_status;
    crs_pkg::t_rem_vec n_a_mag, n_res;
    logic [crs_pkg::LANES-1:0] n_a_neg;
    crs_pkg::t_side    n_a_side;

    crs_delta_unit u_delta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign ce            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = ce && !cfg.busy;

    // Centre each residue about q.
    always_comb begin
        logic [crs_pkg::COEF_W-1:0] x;
        for (int l = 0; l < crs_pkg::LANES; l++) begin
            x = s_axis_tdata[l*crs_pkg::COEF_W +: crs_pkg::COEF_W];
            n_a_neg[l] = 1'b0;
            if (x > {1'b0, cfg.q_half}) begin
                if (x >= cfg.q) begin
                    n_a_mag[l] = x - cfg.q;
                end else begin
                    n_a_mag[l] = cfg.q - x;
                    n_a_neg[l] = 1'b1;
                end
            end else begin
                n_a_mag[l] = x;
            end
        end
        n_a_side.valid = s_axis_tvalid && s_axis_tready;
        n_a_side.last  = s_axis_tlast;
        n_a_side.neg   = n_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
        end else if (ce) begin
            r_a_side <= n_a_side;
            r_b_side <= r_a_side;
        end
        if (ce) begin
            r_a_mag <= n_a_mag;
            for (int l = 0; l < crs_pkg::LANES; l++) begin
                r_b_num[l] <= {1'b0, r_a_mag[l]} + {2'b00, cfg.d_half};
            end
        end
    end

    crs_div_chain u_div_delta (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_den  (cfg.delta),
        .i_num  (r_b_num),
        .i_side (r_b_side),
        .o_quot (w_quot),
        .o_rem  (),
        .o_side (w_q_side)
    );

    crs_div_chain u_div_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_den  (cfg.q),
        .i_num  (w_quot),
        .i_side (w_q_side),
        .o_quot (),
        .o_rem  (w_rem),
        .o_side (w_r_side)
    );

    // Restore the sign modulo q; faults force the residues to zero.
    always_comb begin
        for (int l = 0; l < crs_pkg::LANES; l++) begin
            if (cfg.status != crs_pkg::ST_OK) begin
                n_res[l] = '0;
            end else if (w_r_side.neg[l] && (w_rem[l] != '0)) begin
                n_res[l] = cfg.q - w_rem[l];
            end else begin
                n_res[l] = w_rem[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= w_r_side.valid;
        end
        if (ce) begin
            r_out_res    <= n_res;
            r_out_last   <= w_r_side.last;
            r_out_status <= cfg.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_res};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: test/ciphertext_coefficient_rescale_core_test.sv
// Self-checking testbench of the ciphertext coefficient rescale core.
`timescale 1ns / 100ps

module ciphertext_coefficient_rescale_core_test;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 200;
    localparam logic [crs_pkg::COEF_W-1:0] Q_MAX = {crs_pkg::COEF_W{1'b1}};

    typedef struct {
        logic [crs_pkg::COEF_W-1:0]   r0, r1, r2;
        logic [crs_pkg::STATUS_W-1:0] st;
        logic                         last;
    } t_rescaled;

    // One directed transfer, with the register setting it runs under.
    typedef struct {
        logic [crs_pkg::COEF_W-1:0]   q, t, c0, c1, c2;
        logic                         last;
        logic                         typed;
        logic [crs_pkg::COEF_W-1:0]   e0, e1, e2;
        logic [crs_pkg::STATUS_W-1:0] est;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = crs_pkg::CFG_Q;
    logic [crs_pkg::COEF_W-1:0]    i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [191:0]                  s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [191:0]                  m_axis_tdata;
    logic [crs_pkg::STATUS_W-1:0]  m_axis_tuser;
    logic                          m_axis_tlast;

    logic [crs_pkg::COEF_W-1:0]    model_q = crs_pkg::Q_RESET;
    logic [crs_pkg::COEF_W-1:0]    model_t = crs_pkg::T_RESET;
    t_rescaled                     pending_results[$];
    int                            errors = 0;
    int                            cycles = 0;
    bit                            sender_idles = 1'b1;
    bit                            receiver_stalls = 1'b1;
    int                            stall_left = 0;

    ciphertext_coefficient_rescale_core dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [crs_pkg::COEF_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[crs_pkg::COEF_W-1:0];
    endfunction

    // Centre about q, divide by d with halves away from zero, reduce into [0, q).
    function automatic logic [crs_pkg::COEF_W-1:0] rescale_lane(
            logic [crs_pkg::COEF_W-1:0] x,
            logic [crs_pkg::COEF_W-1:0] q, logic [crs_pkg::COEF_W-1:0] d);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = 1'b0;
        if (x > q / 2) begin
            if (x >= q) begin
                mag = x - q;
            end else begin
                neg = 1'b1;
                mag = q - x;
            end
        end else begin
            mag = x;
        end
        r = (mag + d / 2) / d;
        r = r % q;
        if (neg && r != 0)
            r = q - r;
        return r[crs_pkg::COEF_W-1:0];
    endfunction

    function automatic t_rescaled predict_rescale(logic [crs_pkg::COEF_W-1:0] c0,
            logic [crs_pkg::COEF_W-1:0] c1, logic [crs_pkg::COEF_W-1:0] c2, logic last);
        t_rescaled                  p;
        logic [crs_pkg::COEF_W-1:0] delta;
        p = '{r0: '0, r1: '0, r2: '0, st: crs_pkg::ST_OK, last: last};
        if (model_t == 0) begin
            p.st = crs_pkg::ST_T_ZERO;
            return p;
        end
        delta = model_q / model_t;
        if (delta == 0) begin
            p.st = crs_pkg::ST_DELTA_ZERO;
            return p;
        end
        p.r0 = rescale_lane(c0, model_q, delta);
        p.r1 = rescale_lane(c1, model_q, delta);
        p.r2 = rescale_lane(c2, model_q, delta);
        return p;
    endfunction

    // Waits for the pipeline to empty, then writes both moduli.
    task automatic load_moduli(logic [crs_pkg::COEF_W-1:0] q,
            logic [crs_pkg::COEF_W-1:0] t);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= crs_pkg::CFG_Q;
        i_cfg_data  <= q;
        @(posedge i_clk);
        model_q = q;
        i_cfg_index <= crs_pkg::CFG_T;
        i_cfg_data  <= t;
        @(posedge i_clk);
        model_t = t;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_coefs(logic [crs_pkg::COEF_W-1:0] c0,
            logic [crs_pkg::COEF_W-1:0] c1, logic [crs_pkg::COEF_W-1:0] c2,
            logic last, bit typed, t_rescaled typed_res);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c2, c1, c0};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(typed ? typed_res : predict_rescale(c0, c1, c2, last));
    endtask

    // Output side: random stalls, then a check of every transfer.
    always @(posedge i_clk) begin
        t_rescaled want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            stall_left    <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[62:0] !== want.r0) begin
                    $error("res_zero: expected %0d, got %0d", want.r0, m_axis_tdata[62:0]);
                    errors++;
                end
                if (m_axis_tdata[125:63] !== want.r1) begin
                    $error("res_one: expected %0d, got %0d", want.r1, m_axis_tdata[125:63]);
                    errors++;
                end
                if (m_axis_tdata[188:126] !== want.r2) begin
                    $error("res_two: expected %0d, got %0d", want.r2, m_axis_tdata[188:126]);
                    errors++;
                end
                if (m_axis_tuser !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_out: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row                       rows[$];
        t_rescaled                  typed_res;
        logic [crs_pkg::COEF_W-1:0] q, t, c[3];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: q = 65537, t = 2, so Delta = 32768 and q/2 = 32768.
        rows.push_back('{65537, 2, 0, 0, 0, 0, 1, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{65537, 2, 32768, 32769, 16383, 1, 1, 1, 65536, 0, crs_pkg::ST_OK});
        rows.push_back('{65537, 2, 65537, 65536, 16384, 0, 1, 0, 0, 1, crs_pkg::ST_OK});
        rows.push_back('{65537, 2, Q_MAX, 65538, 49152, 1, 0, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{65537, 2, 32767, 49153, 1, 0, 0, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{Q_MAX, 1, Q_MAX, Q_MAX - 1, Q_MAX / 2, 0, 0, 0, 0, 0,
                         crs_pkg::ST_OK});
        rows.push_back('{Q_MAX, 1, 0, Q_MAX / 2 + 1, 1, 1, 1, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{Q_MAX, Q_MAX, Q_MAX / 2, Q_MAX / 2 + 1, 0, 0, 1,
                         Q_MAX / 2, Q_MAX / 2 + 1, 0, crs_pkg::ST_OK});
        rows.push_back('{Q_MAX, 3, Q_MAX - 5, Q_MAX / 3, Q_MAX / 6, 1, 0, 0, 0, 0,
                         crs_pkg::ST_OK});
        rows.push_back('{Q_MAX, 0, Q_MAX, 5, 0, 1, 1, 0, 0, 0, crs_pkg::ST_T_ZERO});
        rows.push_back('{0, 0, 7, 0, 3, 0, 1, 0, 0, 0, crs_pkg::ST_T_ZERO});
        rows.push_back('{3, 7, 2, 1, Q_MAX, 1, 1, 0, 0, 0, crs_pkg::ST_DELTA_ZERO});
        rows.push_back('{0, 3, 0, 9, 1, 0, 1, 0, 0, 0, crs_pkg::ST_DELTA_ZERO});
        rows.push_back('{1, 1, 0, 1, Q_MAX, 1, 1, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{2, 2, 0, 1, 2, 0, 0, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{2, 1, 1, 3, Q_MAX, 1, 0, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{1000, 7, 999, 500, 501, 0, 0, 0, 0, 0, crs_pkg::ST_OK});
        rows.push_back('{1000, 7, 71, 72, 929, 1, 0, 0, 0, 0, crs_pkg::ST_OK});

        foreach (rows[i]) begin
            if (rows[i].q != model_q || rows[i].t != model_t)
                load_moduli(rows[i].q, rows[i].t);
            typed_res = '{r0: rows[i].e0, r1: rows[i].e1, r2: rows[i].e2,
                          st: rows[i].est, last: rows[i].last};
            send_coefs(rows[i].c0, rows[i].c1, rows[i].c2, rows[i].last,
                       rows[i].typed, typed_res);
        end

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin q = Q_MAX; t = $urandom_range(1, 1000); end
                1: begin q = Q_MAX; t = Q_MAX; end
                2: begin q = rand_word(); t = rand_word() >> $urandom_range(1, 62); end
                3: begin q = $urandom_range(2, 5000); t = $urandom_range(1, 50); end
                4: begin q = rand_word(); t = 0; end
                5: begin q = $urandom_range(2, 100); t = $urandom_range(101, 1000); end
                6: begin q = rand_word() | (63'd1 << 62); t = 1; end
                default: begin q = rand_word() >> $urandom_range(0, 40);
                               t = $urandom_range(1, 9); end
            endcase
            if (q < 2) q = 2;
            load_moduli(q, t);
            sender_idles    = (phase != 3);
            receiver_stalls = (phase != 6);
            for (int n = 0; n < 48; n++) begin
                for (int k = 0; k < 3; k++)
                    c[k] = ($urandom_range(0, 9) == 0) ? rand_word() : rand_word() % q;
                send_coefs(c[0], c[1], c[2], $urandom_range(0, 7) == 0, 0, typed_res);
                if (n == 24 && phase == 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
